>>> rtl/core/three_wire_rtc_bus_master_assert.svh
// Assertion macros for the three-wire serial bus master checker.
// Used by rtcb_checker.sv; no other dependencies.
`ifndef THREE_WIRE_RTC_BUS_MASTER_ASSERT_SVH
`define THREE_WIRE_RTC_BUS_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low.
`define RTCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, masked while rst_n is low.
`define RTCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/rtcb_pkg.sv
// Shared types, codes and constants of the three-wire serial bus master.
// No dependencies; imported by rtcb_cfg, rtcb_seq and the top level.
`default_nettype none

package rtcb_pkg;

  localparam int DLY_W       = 12;
  localparam int WAIT_W      = 17;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int MODE_W      = 3;
  localparam int BURST_BYTES = 8;

  // Wait lengths in delay units
  localparam logic [4:0] UNITS_SHORT = 5'd5;
  localparam logic [4:0] UNITS_BIT   = 5'd10;
  localparam logic [4:0] UNITS_LONG  = 5'd30;

  // Command bytes
  localparam logic [7:0] CMD_BURST_WR = 8'hBE;
  localparam logic [7:0] CMD_BURST_RD = 8'hBF;

  // Request kinds carried on the input beat
  localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE_WR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SINGLE_RD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BURST_WR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BURST_RD  = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PRE_CMD   = 3'd1,
    PH_WB_HIGH   = 3'd2,
    PH_WB_LOW    = 3'd3,
    PH_POST_CMD  = 3'd4,
    PH_RB_SAMPLE = 3'd5,
    PH_RB_HIGH   = 3'd6,
    PH_RB_LOW    = 3'd7
  } phase_t;

  typedef struct packed {
    logic [WAIT_W-1:0] w_short;
    logic [WAIT_W-1:0] w_bit;
    logic [WAIT_W-1:0] w_long;
  } waits_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] reg_addr;
    logic [DATA_W-1:0] write_data;
    logic              io_in;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              done_res;
    logic              accepted;
    logic              busy_res;
    logic              io_drive;
    logic              io_out;
    logic              serial_clock;
    logic              chip_enable;
  } result_t;

  // Wait length in ticks minus one; a zero unit counts as one tick
  function automatic logic [WAIT_W-1:0] wait_ticks(input logic [4:0]       units,
                                                   input logic [DLY_W-1:0] dly);
    logic [WAIT_W-1:0] u;
    u = (dly == '0) ? WAIT_W'(1) : WAIT_W'(dly);
    return WAIT_W'(WAIT_W'(units) * u - WAIT_W'(1));
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rtcb_cfg.sv
// Delay-unit register; holds the tick counts minus one of the three wait lengths.
// Depends on rtcb_pkg.
`default_nettype none

module rtcb_cfg
  import rtcb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [DLY_W-1:0] cfg_wdata,
  output waits_t                waits
);

  waits_t waits_r, waits_nxt;

  always_comb begin
    waits_nxt = waits_r;
    if (cfg_we) begin
      waits_nxt.w_short = wait_ticks(UNITS_SHORT, cfg_wdata);
      waits_nxt.w_bit   = wait_ticks(UNITS_BIT, cfg_wdata);
      waits_nxt.w_long  = wait_ticks(UNITS_LONG, cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waits_r.w_short <= wait_ticks(UNITS_SHORT, DLY_W'(1));
      waits_r.w_bit   <= wait_ticks(UNITS_BIT, DLY_W'(1));
      waits_r.w_long  <= wait_ticks(UNITS_LONG, DLY_W'(1));
    end else begin
      waits_r <= waits_nxt;
    end
  end

  assign waits = waits_r;

endmodule

`default_nettype wire

>>> rtl/core/rtcb_seq.sv
// Pin sequencer: one tick of the bus state machine per step.
// Depends on rtcb_pkg; wait lengths come from rtcb_cfg.
`default_nettype none

module rtcb_seq
  import rtcb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   step_en,
  input  wire item_t  item,
  input  wire waits_t waits,
  output result_t     res
);

  phase_t            phase_r, phase_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [3:0]        byte_r, byte_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [MODE_W-1:0] op_r, op_nxt;
  logic [DATA_W-1:0] wbuf_r, wbuf_nxt;
  logic [DATA_W-1:0] rbuf_r, rbuf_nxt;
  logic              ce_r, ce_nxt, ck_r, ck_nxt, io_r, io_nxt, drv_r, drv_nxt;
  logic              done;

  logic       start, go, last_bit, more_wr, more_rd, is_wr_op;
  logic [2:0] bit_inc, byte_prev;
  logic [7:0] next_wr_byte, cmd_byte;

  assign start     = (phase_r == PH_IDLE) &&
                     (item.mode == MODE_SINGLE_WR || item.mode == MODE_SINGLE_RD ||
                      item.mode == MODE_BURST_WR  || item.mode == MODE_BURST_RD);
  assign go        = (phase_r != PH_IDLE) && (wait_r == '0);
  assign last_bit  = (bit_r == 3'd7);
  assign bit_inc   = bit_r + 3'd1;
  assign byte_prev = byte_r[2:0] - 3'd1;
  assign more_wr   = (op_r == MODE_BURST_WR) && (byte_r < 4'(BURST_BYTES));
  assign more_rd   = (op_r == MODE_BURST_RD) && (byte_r < 4'(BURST_BYTES));
  assign is_wr_op  = (op_r == MODE_SINGLE_WR) || (op_r == MODE_BURST_WR);
  assign next_wr_byte = wbuf_r[{byte_r[2:0], 3'b000} +: 8];

  always_comb begin
    case (item.mode)
      MODE_SINGLE_WR: cmd_byte = {1'b1, item.reg_addr, 1'b0};
      MODE_SINGLE_RD: cmd_byte = {1'b1, item.reg_addr, 1'b1};
      MODE_BURST_WR:  cmd_byte = CMD_BURST_WR;
      default:        cmd_byte = CMD_BURST_RD;
    endcase
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (start) begin
      phase_nxt = (item.mode == MODE_SINGLE_RD) ? PH_PRE_CMD : PH_WB_HIGH;
    end else if (go) begin
      case (phase_r)
        PH_PRE_CMD:   phase_nxt = PH_WB_HIGH;
        PH_WB_HIGH:   phase_nxt = PH_WB_LOW;
        PH_RB_HIGH:   phase_nxt = PH_RB_LOW;
        PH_WB_LOW: begin
          if (!last_bit)            phase_nxt = PH_WB_HIGH;
          else if (byte_r == '0)    phase_nxt = PH_POST_CMD;
          else if (more_wr)         phase_nxt = PH_WB_HIGH;
          else                      phase_nxt = PH_IDLE;
        end
        PH_POST_CMD:  phase_nxt = is_wr_op ? PH_WB_HIGH : PH_RB_SAMPLE;
        PH_RB_SAMPLE: phase_nxt = PH_RB_HIGH;
        PH_RB_LOW: begin
          if (!last_bit)            phase_nxt = PH_RB_HIGH;
          else if (more_rd)         phase_nxt = PH_RB_SAMPLE;
          else                      phase_nxt = PH_IDLE;
        end
        default:      phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Counters, buffers and pin levels
  always_comb begin
    wait_nxt  = wait_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    shift_nxt = shift_r;
    op_nxt    = op_r;
    wbuf_nxt  = wbuf_r;
    rbuf_nxt  = rbuf_r;
    ce_nxt    = ce_r;
    ck_nxt    = ck_r;
    io_nxt    = io_r;
    drv_nxt   = drv_r;
    done      = 1'b0;
    if (start) begin
      op_nxt    = item.mode;
      wbuf_nxt  = item.write_data;
      rbuf_nxt  = '0;
      byte_nxt  = '0;
      ce_nxt    = 1'b1;
      shift_nxt = cmd_byte;
      if (item.mode == MODE_SINGLE_RD) begin
        wait_nxt = waits.w_long;
      end else begin
        bit_nxt  = '0;
        drv_nxt  = 1'b1;
        io_nxt   = cmd_byte[0];
        wait_nxt = waits.w_bit;
      end
    end else if ((phase_r != PH_IDLE) && !go) begin
      wait_nxt = wait_r - WAIT_W'(1);
    end else if (go) begin
      case (phase_r)
        PH_PRE_CMD: begin
          bit_nxt  = '0;
          drv_nxt  = 1'b1;
          io_nxt   = shift_r[0];
          wait_nxt = waits.w_bit;
        end
        PH_WB_HIGH, PH_RB_HIGH: begin
          ck_nxt   = 1'b1;
          wait_nxt = waits.w_bit;
        end
        PH_WB_LOW: begin
          ck_nxt = 1'b0;
          if (!last_bit) begin
            bit_nxt  = bit_inc;
            io_nxt   = shift_r[bit_inc];
            wait_nxt = waits.w_bit;
          end else if (byte_r == '0) begin
            io_nxt   = 1'b1;
            wait_nxt = (op_r == MODE_SINGLE_WR) ? waits.w_bit : waits.w_long;
          end else if (more_wr) begin
            // next burst byte; io level comes straight from its bit 0
            byte_nxt  = byte_r + 4'd1;
            shift_nxt = next_wr_byte;
            bit_nxt   = '0;
            drv_nxt   = 1'b1;
            io_nxt    = next_wr_byte[0];
            wait_nxt  = waits.w_bit;
          end else begin
            io_nxt   = 1'b1;
            ce_nxt   = 1'b0;
            done     = 1'b1;
            wait_nxt = '0;
          end
        end
        PH_POST_CMD: begin
          byte_nxt = 4'd1;
          bit_nxt  = '0;
          if (is_wr_op) begin
            shift_nxt = wbuf_r[7:0];
            drv_nxt   = 1'b1;
            io_nxt    = wbuf_r[0];
            wait_nxt  = waits.w_bit;
          end else begin
            drv_nxt   = 1'b0;
            shift_nxt = '0;
            wait_nxt  = waits.w_short;
          end
        end
        PH_RB_SAMPLE: begin
          shift_nxt = shift_r | (8'(item.io_in) << bit_r);
          wait_nxt  = waits.w_bit;
        end
        PH_RB_LOW: begin
          ck_nxt = 1'b0;
          if (!last_bit) begin
            bit_nxt   = bit_inc;
            shift_nxt = shift_r | (8'(item.io_in) << bit_inc);
            wait_nxt  = waits.w_bit;
          end else begin
            drv_nxt = 1'b1;
            rbuf_nxt[{byte_prev, 3'b000} +: 8] = rbuf_r[{byte_prev, 3'b000} +: 8] | shift_r;
            if (more_rd) begin
              byte_nxt  = byte_r + 4'd1;
              drv_nxt   = 1'b0;
              shift_nxt = '0;
              bit_nxt   = '0;
              wait_nxt  = waits.w_short;
            end else begin
              ce_nxt   = 1'b0;
              done     = 1'b1;
              wait_nxt = '0;
            end
          end
        end
        default: wait_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= '0;
      bit_r   <= '0;
      byte_r  <= '0;
      shift_r <= '0;
      op_r    <= MODE_NONE;
      wbuf_r  <= '0;
      rbuf_r  <= '0;
      ce_r    <= 1'b0;
      ck_r    <= 1'b1;
      io_r    <= 1'b1;
      drv_r   <= 1'b1;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      op_r    <= op_nxt;
      wbuf_r  <= wbuf_nxt;
      rbuf_r  <= rbuf_nxt;
      ce_r    <= ce_nxt;
      ck_r    <= ck_nxt;
      io_r    <= io_nxt;
      drv_r   <= drv_nxt;
    end
  end

  assign res.chip_enable  = ce_nxt;
  assign res.serial_clock = ck_nxt;
  assign res.io_out       = io_nxt;
  assign res.io_drive     = drv_nxt;
  assign res.busy_res     = (phase_nxt != PH_IDLE);
  assign res.accepted     = start;
  assign res.done_res     = done;
  assign res.read_data    = rbuf_nxt;

endmodule

`default_nettype wire

>>> rtl/core/three_wire_rtc_bus_master.sv
// Top level of the three-wire serial bus master: beat registers around the sequencer.
// Depends on rtcb_pkg, rtcb_cfg and rtcb_seq.
`default_nettype none

// Three-wire serial bus master (chip enable, serial clock, bidirectional data),
// LSB first. Every input beat is one timing tick and yields exactly one result
// beat showing the pin levels after that tick. in_tuser carries the request
// kind: 0 tick only, 1 single write, 2 single read, 3 burst write (8 bytes),
// 4 burst read (8 bytes); 5..7 act as tick only, and requests arriving while a
// transaction runs are dropped (accepted bit low). Rate: one beat per clock unless
// out_tready stalls the result register; a beat passes the input register, then the
// result register, with the single tick of the sequencer state machine between the
// two. Each wait of W delay units lasts W times the delay unit in ticks, i.e.
// in beats, not clock cycles. cfg_wdata sets the ticks per delay unit (0 counts as 1,
// reset value 1); write it only while no transaction is in progress.
module three_wire_rtc_bus_master
  import rtcb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input beats
  input  wire logic             in_tvalid,
  output      logic             in_tready,
  // [5:0] reg_addr, [69:6] write_data, [70] io_in, [71] zero
  input  wire logic [71:0]      in_tdata,
  // [2:0] mode
  input  wire logic [2:0]       in_tuser,
  // result beats
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  // [0] chip_enable, [1] serial_clock, [2] io_out, [3] io_drive,
  // [4] busy_res, [5] accepted, [6] done_res, [70:7] read_data, [71] zero
  output      logic [71:0]      out_tdata,
  // delay-unit register
  input  wire logic             cfg_we,
  input  wire logic [DLY_W-1:0] cfg_wdata
);

  logic    in_valid_r, in_valid_nxt;
  item_t   item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res;
  waits_t  waits;
  logic    step_en;

  // Advance the sequencer when a tick is held and the result slot frees up
  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.mode       <= in_tuser;
      item_r.reg_addr   <= in_tdata[5:0];
      item_r.write_data <= in_tdata[69:6];
      item_r.io_in      <= in_tdata[70];
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  rtcb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .waits     (waits)
  );

  rtcb_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .waits   (waits),
    .res     (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.read_data, res_r.done_res, res_r.accepted,
                       res_r.busy_res, res_r.io_drive, res_r.io_out,
                       res_r.serial_clock, res_r.chip_enable};

endmodule

`default_nettype wire

>>> rtl/core/rtcb_checker.sv
// Port-level checker for the three-wire serial bus master, bound to the top.
// Depends on three_wire_rtc_bus_master_assert.svh only.
`default_nettype none

`include "three_wire_rtc_bus_master_assert.svh"

module rtcb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);

  logic out_beat, out_stall;
  logic o_ce, o_busy, o_acc, o_done;

  assign out_beat  = out_tvalid && out_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign o_ce      = out_tdata[0];
  assign o_busy    = out_tdata[4];
  assign o_acc     = out_tdata[5];
  assign o_done    = out_tdata[6];

  `RTCB_ASSERT_NOW(a_accept_starts, out_beat && o_acc, o_busy && o_ce, "accept without busy")
  `RTCB_ASSERT_NOW(a_done_ends, out_beat && o_done, !(o_busy || o_ce || o_acc), "busy at done")
  `RTCB_ASSERT_NOW(a_ce_tracks_busy, out_tvalid, o_ce == o_busy, "chip enable differs from busy")
  `RTCB_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "held beat changed")

endmodule

bind three_wire_rtc_bus_master rtcb_checker u_rtcb_checker (.*);

`default_nettype wire
